FILE: sv/bounded_vector_engine_defines.svh
// Assertion macros for the top-level RTL file of the bounded vector engine.
// Each macro expects the module to have a clock named clk and an
// active-low reset named rst_n.
`ifndef BOUNDED_VECTOR_ENGINE_DEFINES_SVH
`define BOUNDED_VECTOR_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BVE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bve_pkg.sv
// Package with the sizes, request and status codes and word helpers of the vector engine.
`timescale 1ns / 1ps

package bve_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int IDX_BITS  = 6;
    localparam int CMP_BITS  = (CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS;

    typedef enum logic [2:0] {
        REQ_APPEND     = 3'd0,
        REQ_POP        = 3'd1,
        REQ_REVERSE    = 3'd2,
        REQ_REMOVE_AT  = 3'd3,
        REQ_REMOVE_ALL = 3'd4,
        REQ_READ       = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Sign-extend the 32-bit input word and keep its low WORD_BITS bits.
    function automatic logic [WORD_BITS-1:0] to_word(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[WORD_BITS-1:0];
    endfunction

    // Sign-extend a stored word to the 32-bit result field.
    function automatic logic signed [31:0] word_to_out(input logic [WORD_BITS-1:0] w);
        logic signed [WORD_BITS-1:0] s;
        logic signed [63:0]          e;
        s = w;
        e = 64'(s);
        return e[31:0];
    endfunction

endpackage

FILE: sv/bve_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/bounded_vector_engine.sv
// Top level of the bounded vector engine: an ordered store of signed words with a fill count.
//
//  Channel | Direction | Handshake            | Beat fields
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid/req_stall  | req_type, value, index
//  rsp     | out       | rsp_valid/rsp_stall  | read_value, count, removed, status
//
// Remove-at-index, remove-all and reverse (of two or more entries) walk the stored
// entries, paced by the single read port and single write port of the entry RAM.
// Reset clears the fill count and control state at once; the RAM needs no clearing.
// Requests stall during work; a stalled result waits in the output register meanwhile.
`timescale 1ns / 1ps

`include "bounded_vector_engine_defines.svh"

module bounded_vector_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [5:0]         index,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] read_value,
    output logic [6:0]         count,
    output logic [6:0]         removed,
    output logic [1:0]         status
);

    // The engine is idle, walks the store for a compaction or a reversal,
    // waits for RAM read data, or holds a finished result until the output
    // register is free.
    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPACT,
        S_REVERSE,
        S_READ,
        S_DONE
    } state_t;

    state_t state_reg;

    // Store bookkeeping.
    logic [bve_pkg::CNT_BITS-1:0]  fill_reg;
    logic [bve_pkg::WORD_BITS-1:0] val_reg;

    // Compaction walk: a read pointer running ahead of a write pointer, and a
    // flag saying that the RAM read data of the previous cycle is valid.
    logic [bve_pkg::CNT_BITS-1:0]  rptr_reg;
    logic [bve_pkg::CNT_BITS-1:0]  wptr_reg;
    logic                          pend_reg;
    logic                          keep_all_reg;

    // Reversal walk: pair number and phase (low entry, then high entry).
    logic [bve_pkg::CNT_BITS-1:0]  pair_reg;
    logic                          phase_reg;
    logic [bve_pkg::WORD_BITS-1:0] tmp_reg;

    // Result of the request in progress.
    logic signed [31:0]            res_read_reg;
    logic [6:0]                    res_removed_reg;
    bve_pkg::status_t              res_status_reg;

    // Output register.
    logic                          rsp_valid_reg;
    logic signed [31:0]            read_value_reg;
    logic [6:0]                    count_reg;
    logic [6:0]                    removed_reg;
    bve_pkg::status_t              status_reg;

    // RAM port signals.
    logic                          ram_we;
    logic                          ram_re;
    logic [bve_pkg::ADDR_BITS-1:0] ram_waddr;
    logic [bve_pkg::ADDR_BITS-1:0] ram_raddr;
    logic [bve_pkg::WORD_BITS-1:0] ram_wdata;
    logic [bve_pkg::WORD_BITS-1:0] ram_rdata;

    logic                          req_accept;
    bve_pkg::req_t                 req_code;
    logic                          full;
    logic                          in_range;
    logic [bve_pkg::CNT_BITS-1:0]  half;
    logic                          keep;
    logic                          comp_rd;
    logic                          comp_wr;
    logic                          rev_rd;
    logic                          rev_wr;
    logic                          out_free;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign req_code   = bve_pkg::req_t'(req_type);

    assign full     = (fill_reg == bve_pkg::CNT_BITS'(bve_pkg::DEPTH));
    assign in_range = (bve_pkg::CMP_BITS'(index) < bve_pkg::CMP_BITS'(fill_reg));
    assign half     = fill_reg >> 1;

    // A compaction keeps every entry behind the removed index, or every
    // entry that differs from the value being removed.
    assign keep    = keep_all_reg || (ram_rdata != val_reg);
    assign comp_rd = (rptr_reg < fill_reg);
    assign comp_wr = pend_reg && keep;

    // Reads of pair p overlap the write-back of pair p - 1.
    assign rev_rd = (pair_reg < half);
    assign rev_wr = (pair_reg != '0);

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        ram_wdata = ram_rdata;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_we    = req_accept && (req_code == bve_pkg::REQ_APPEND) && !full;
                ram_waddr = bve_pkg::ADDR_BITS'(fill_reg);
                ram_wdata = bve_pkg::to_word(value);
                ram_re    = req_accept && (req_code == bve_pkg::REQ_READ) && in_range;
                ram_raddr = bve_pkg::ADDR_BITS'(index);
            end
            S_COMPACT:
            begin
                ram_re    = comp_rd;
                ram_raddr = bve_pkg::ADDR_BITS'(rptr_reg);
                ram_we    = comp_wr;
                ram_waddr = bve_pkg::ADDR_BITS'(wptr_reg);
                ram_wdata = ram_rdata;
            end
            S_REVERSE:
            begin
                ram_re = rev_rd;
                ram_we = rev_wr;
                if (!phase_reg)
                begin
                    // Read the low entry of this pair and write the high
                    // entry of the previous pair into its low slot.
                    ram_raddr = bve_pkg::ADDR_BITS'(pair_reg);
                    ram_waddr = bve_pkg::ADDR_BITS'(pair_reg - bve_pkg::CNT_BITS'(1));
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    // Read the high entry of this pair and write the saved
                    // low entry of the previous pair into its high slot.
                    ram_raddr = bve_pkg::ADDR_BITS'(fill_reg - pair_reg
                                                    - bve_pkg::CNT_BITS'(1));
                    ram_waddr = bve_pkg::ADDR_BITS'(fill_reg - pair_reg);
                    ram_wdata = tmp_reg;
                end
            end
            S_READ,
            S_DONE:
            begin
                ram_we = 1'b0;
                ram_re = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
                ram_re = 1'b0;
            end
        endcase
    end

    bve_ram #(
        .WIDTH (bve_pkg::WORD_BITS),
        .DEPTH (bve_pkg::DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        res_read_reg    <= '0;
                        res_removed_reg <= '0;
                        res_status_reg  <= bve_pkg::ST_OK;
                        pend_reg        <= 1'b0;
                        phase_reg       <= 1'b0;
                        pair_reg        <= '0;
                        val_reg         <= bve_pkg::to_word(value);
                        state_reg       <= S_DONE;
                        unique case (req_code)
                            bve_pkg::REQ_APPEND:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= bve_pkg::ST_FULL;
                                end
                                else
                                begin
                                    fill_reg <= fill_reg + bve_pkg::CNT_BITS'(1);
                                end
                            end
                            bve_pkg::REQ_POP:
                            begin
                                if (fill_reg == '0)
                                begin
                                    res_status_reg <= bve_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    fill_reg        <= fill_reg - bve_pkg::CNT_BITS'(1);
                                    res_removed_reg <= 7'd1;
                                end
                            end
                            bve_pkg::REQ_REVERSE:
                            begin
                                if (half != '0)
                                begin
                                    state_reg <= S_REVERSE;
                                end
                            end
                            bve_pkg::REQ_REMOVE_AT:
                            begin
                                if (!in_range)
                                begin
                                    res_status_reg <= bve_pkg::ST_RANGE;
                                end
                                else
                                begin
                                    rptr_reg     <= bve_pkg::CNT_BITS'(index)
                                                    + bve_pkg::CNT_BITS'(1);
                                    wptr_reg     <= bve_pkg::CNT_BITS'(index);
                                    keep_all_reg <= 1'b1;
                                    state_reg    <= S_COMPACT;
                                end
                            end
                            bve_pkg::REQ_REMOVE_ALL:
                            begin
                                rptr_reg     <= '0;
                                wptr_reg     <= '0;
                                keep_all_reg <= 1'b0;
                                state_reg    <= S_COMPACT;
                            end
                            bve_pkg::REQ_READ:
                            begin
                                if (!in_range)
                                begin
                                    res_status_reg <= bve_pkg::ST_RANGE;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_COMPACT:
                begin
                    if (comp_rd)
                    begin
                        rptr_reg <= rptr_reg + bve_pkg::CNT_BITS'(1);
                    end
                    pend_reg <= comp_rd;
                    if (comp_wr)
                    begin
                        wptr_reg <= wptr_reg + bve_pkg::CNT_BITS'(1);
                    end
                    if (!comp_rd && !pend_reg)
                    begin
                        // Every kept entry has been written back below the
                        // write pointer, which is now the new fill.
                        fill_reg        <= wptr_reg;
                        res_removed_reg <= 7'(fill_reg - wptr_reg);
                        state_reg       <= S_DONE;
                    end
                end

                S_REVERSE:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        tmp_reg  <= ram_rdata;
                        pair_reg <= pair_reg + bve_pkg::CNT_BITS'(1);
                        if (pair_reg == half)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_READ:
                begin
                    res_read_reg <= bve_pkg::word_to_out(ram_rdata);
                    state_reg    <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        read_value_reg <= res_read_reg;
                        count_reg      <= 7'(fill_reg);
                        removed_reg    <= res_removed_reg;
                        status_reg     <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;
    assign removed    = removed_reg;
    assign status     = status_reg;

    `BVE_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= bve_pkg::CNT_BITS'(bve_pkg::DEPTH), "fill count above capacity")
    `BVE_ASSERT_SAME(a_compact_order, (state_reg == S_COMPACT) && ram_we, wptr_reg < rptr_reg, "compaction write pointer caught up with read pointer")
    `BVE_ASSERT_SAME(a_reverse_apart, (state_reg == S_REVERSE) && ram_we && ram_re, ram_waddr != ram_raddr, "reversal reads and writes the same entry")
    `BVE_ASSERT_SAME(a_full_flag, rsp_valid_reg && (status_reg == bve_pkg::ST_FULL), count_reg == 7'(bve_pkg::DEPTH), "full status with room left")
    `BVE_ASSERT_NEXT(a_busy_after_accept, req_accept, req_stall, "request taken while engine still idle")

endmodule
